// ===== hdl/mcdd_pkg.sv =====
// mcdd_pkg: shared types, codes and defaults for the mouse click and drag decoder
// used by mcdd_core, mouse_click_drag_decoder and mcdd_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mcdd_pkg;

    // default pointer coordinate width
    localparam int COORD_BITS_DEF = 12;

    // register reset values and the motion saturation limit
    localparam logic [1:0]  CLICK_MODE_RST = 2'd1;
    localparam logic [15:0] MOVE_LIMIT_RST = 16'd5;
    localparam logic [15:0] MOTION_MAX     = 16'hFFFF;

    // click modes
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    // configuration register indexes
    localparam logic REG_CLICK_MODE = 1'b0;
    localparam logic REG_MOVE_LIMIT = 1'b1;

    // event codes, anything else acts as a move
    localparam logic [3:0] EV_LDOWN = 4'd1;
    localparam logic [3:0] EV_RDOWN = 4'd2;
    localparam logic [3:0] EV_LUP   = 4'd4;
    localparam logic [3:0] EV_RUP   = 4'd5;
    localparam logic [3:0] EV_LDBL  = 4'd7;
    localparam logic [3:0] EV_RDBL  = 4'd8;

    // button flag values
    localparam logic [5:0] FLAGS_LEFT_ONLY  = 6'd1;
    localparam logic [5:0] FLAGS_RIGHT_ONLY = 6'd2;
    localparam logic [5:0] FLAGS_NONE       = 6'd0;

    // result kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PAGE    = 2'd1;
    localparam logic [1:0] KIND_POINT   = 2'd2;
    localparam logic [1:0] KIND_SEGMENT = 2'd3;

    // page steps, same codes as the press direction
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_NEXT = 2'b01;
    localparam logic [1:0] STEP_PREV = 2'b11;

    // tracked press direction
    typedef enum logic [1:0] {
        DIR_NONE  = 2'b00,
        DIR_LEFT  = 2'b01,
        DIR_RIGHT = 2'b11
    } dir_t;

    // control state passed between the top level and the decode core
    typedef struct packed {
        logic pen_valid;
        dir_t press_dir;
    } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/mouse_click_drag_decoder.sv =====
// mouse_click_drag_decoder: top level, input register, decode core, state and result register
// depends on mcdd_pkg and mcdd_core
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    tuser event_code, tdata pos_x, pos_y, button_flags
//  m_*       out   m_tvalid/m_tready    tuser result_kind, tdata page_step, from_x..to_y
//  cfg_*     in    cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
//  one request in, one result out, one request per cycle sustained while m_tready is high
//  a request passes the input register, then the decode core into the result register
//  state (pen, press tracking) updates as a request moves into the result register
//  a stalled result register holds; the input register still takes one more request
//  reset clears the state and loads click_mode 1, click_move_limit 5
//  cfg_ready is always high; write registers only while the block is idle

module mouse_click_drag_decoder import mcdd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // input requests
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    input  wire logic [3:0]                               s_tuser,  // event_code
    // pos_x, pos_y, button_flags, zero pad
    input  wire logic [((2*COORD_BITS+6+7)/8)*8-1:0]      s_tdata,
    // results
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    output logic [1:0]                                    m_tuser,  // result_kind
    // page_step, from_x, from_y, to_x, to_y, zero pad
    output logic [((2+4*COORD_BITS+7)/8)*8-1:0]           m_tdata,
    // register writes
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic                                     cfg_index,
    input  wire logic [15:0]                              cfg_data
);

    localparam int C          = COORD_BITS;
    localparam int OUT_USED_W = 2 + 4 * C;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // configuration registers
    logic [1:0]  click_mode_reg;
    logic [15:0] click_move_limit_reg;

    // input register
    logic         s1_valid_reg;
    logic [3:0]   s1_event_reg;
    logic [C-1:0] s1_x_reg;
    logic [C-1:0] s1_y_reg;
    logic [5:0]   s1_flags_reg;

    // decoder state
    ctl_t         ctl_reg;
    logic [C-1:0] pen_x_reg;
    logic [C-1:0] pen_y_reg;
    logic [C-1:0] press_x_reg;
    logic [C-1:0] press_y_reg;
    logic [15:0]  press_motion_reg;

    // result register
    logic         out_valid_reg;
    logic [1:0]   out_kind_reg;
    logic [1:0]   out_step_reg;
    logic [C-1:0] out_from_x_reg;
    logic [C-1:0] out_from_y_reg;
    logic [C-1:0] out_to_x_reg;
    logic [C-1:0] out_to_y_reg;

    // core outputs
    ctl_t         ctl_next;
    logic         pen_load;
    logic [C-1:0] press_x_next;
    logic [C-1:0] press_y_next;
    logic [15:0]  press_motion_next;
    logic [1:0]   kind_next;
    logic [1:0]   step_next;
    logic [C-1:0] from_x_next;
    logic [C-1:0] from_y_next;
    logic [C-1:0] to_x_next;
    logic [C-1:0] to_y_next;

    logic s1_move;
    logic in_acc;

    // the request in the input register moves on when the result register is free
    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign in_acc   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_mode_reg       <= CLICK_MODE_RST;
            click_move_limit_reg <= MOVE_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CLICK_MODE: click_mode_reg       <= cfg_data[1:0];
                REG_MOVE_LIMIT: click_move_limit_reg <= cfg_data;
                default:        click_mode_reg       <= click_mode_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_event_reg <= s_tuser;
            s1_x_reg     <= s_tdata[C-1:0];
            s1_y_reg     <= s_tdata[2*C-1:C];
            s1_flags_reg <= s_tdata[2*C+5:2*C];
        end
    end

    mcdd_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .click_mode        (click_mode_reg),
        .click_move_limit  (click_move_limit_reg),
        .event_code        (s1_event_reg),
        .pos_x             (s1_x_reg),
        .pos_y             (s1_y_reg),
        .button_flags      (s1_flags_reg),
        .ctl               (ctl_reg),
        .pen_x             (pen_x_reg),
        .pen_y             (pen_y_reg),
        .press_x           (press_x_reg),
        .press_y           (press_y_reg),
        .press_motion      (press_motion_reg),
        .ctl_next          (ctl_next),
        .pen_load          (pen_load),
        .press_x_next      (press_x_next),
        .press_y_next      (press_y_next),
        .press_motion_next (press_motion_next),
        .result_kind       (kind_next),
        .page_step         (step_next),
        .from_x            (from_x_next),
        .from_y            (from_y_next),
        .to_x              (to_x_next),
        .to_y              (to_y_next)
    );

    // state commits once per request, as it enters the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.pen_valid <= 1'b0;
            ctl_reg.press_dir <= DIR_NONE;
            pen_x_reg         <= '0;
            pen_y_reg         <= '0;
            press_x_reg       <= '0;
            press_y_reg       <= '0;
            press_motion_reg  <= '0;
        end
        else if (s1_move)
        begin
            ctl_reg          <= ctl_next;
            press_x_reg      <= press_x_next;
            press_y_reg      <= press_y_next;
            press_motion_reg <= press_motion_next;
            if (pen_load)
            begin
                pen_x_reg <= s1_x_reg;
                pen_y_reg <= s1_y_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_kind_reg   <= kind_next;
            out_step_reg   <= step_next;
            out_from_x_reg <= from_x_next;
            out_from_y_reg <= from_y_next;
            out_to_x_reg   <= to_x_next;
            out_to_y_reg   <= to_y_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_to_y_reg, out_to_x_reg,
                       out_from_y_reg, out_from_x_reg, out_step_reg};

endmodule

`default_nettype wire

// ===== hdl/mcdd_core.sv =====
// mcdd_core: single-pass decode of one mouse event into a result and next state
// depends on mcdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mcdd_core import mcdd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic [1:0]            click_mode,
    input  wire logic [15:0]           click_move_limit,
    input  wire logic [3:0]            event_code,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire logic [5:0]            button_flags,
    input  wire ctl_t                  ctl,
    input  wire logic [COORD_BITS-1:0] pen_x,
    input  wire logic [COORD_BITS-1:0] pen_y,
    input  wire logic [COORD_BITS-1:0] press_x,
    input  wire logic [COORD_BITS-1:0] press_y,
    input  wire logic [15:0]           press_motion,
    output ctl_t                       ctl_next,
    output logic                       pen_load,
    output logic [COORD_BITS-1:0]      press_x_next,
    output logic [COORD_BITS-1:0]      press_y_next,
    output logic [15:0]                press_motion_next,
    output logic [1:0]                 result_kind,
    output logic [1:0]                 page_step,
    output logic [COORD_BITS-1:0]      from_x,
    output logic [COORD_BITS-1:0]      from_y,
    output logic [COORD_BITS-1:0]      to_x,
    output logic [COORD_BITS-1:0]      to_y
);

    localparam int SUM_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SUM_W-1:0]      sum;
    logic [15:0]           motion_upd;
    logic [COORD_BITS-1:0] px_upd;
    logic [COORD_BITS-1:0] py_upd;
    logic                  tracking;
    logic                  is_down;
    logic                  released;
    logic                  page;
    logic [1:0]            step;
    dir_t                  dir_next;

    assign dx = (press_x > pos_x) ? (press_x - pos_x) : (pos_x - press_x);
    assign dy = (press_y > pos_y) ? (press_y - pos_y) : (pos_y - press_y);
    assign sum = SUM_W'(press_motion) + SUM_W'(dx) + SUM_W'(dy);

    assign tracking   = (ctl.press_dir != DIR_NONE);
    assign motion_upd = !tracking ? press_motion :
                        (sum > SUM_W'(MOTION_MAX)) ? MOTION_MAX : sum[15:0];
    assign px_upd     = tracking ? pos_x : press_x;
    assign py_upd     = tracking ? pos_y : press_y;

    assign is_down  = (event_code == EV_LDOWN) || (event_code == EV_RDOWN);
    // press ends on its up event or when its button is no longer held
    assign released = ((ctl.press_dir == DIR_LEFT) &&
                       ((event_code == EV_LUP) || !button_flags[0])) ||
                      ((ctl.press_dir == DIR_RIGHT) &&
                       ((event_code == EV_RUP) || !button_flags[1]));

    always_comb
    begin
        page              = 1'b0;
        step              = STEP_ZERO;
        dir_next          = ctl.press_dir;
        press_x_next      = press_x;
        press_y_next      = press_y;
        press_motion_next = press_motion;
        if (click_mode == MODE_DOUBLE)
        begin
            if (event_code == EV_LDBL)
            begin
                page = 1'b1;
                step = STEP_NEXT;
            end
            else if (event_code == EV_RDBL)
            begin
                page = 1'b1;
                step = STEP_PREV;
            end
        end
        else if (click_mode == MODE_SINGLE)
        begin
            press_x_next      = px_upd;
            press_y_next      = py_upd;
            press_motion_next = motion_upd;
            if (is_down)
            begin
                if (tracking)
                begin
                    // any down event while a button is held cancels the press
                    dir_next = DIR_NONE;
                end
                else
                begin
                    if ((event_code == EV_LDOWN) &&
                        ((button_flags == FLAGS_LEFT_ONLY) || (button_flags == FLAGS_NONE)))
                        dir_next = DIR_LEFT;
                    else if ((button_flags == FLAGS_RIGHT_ONLY) ||
                             (button_flags == FLAGS_NONE))
                        dir_next = DIR_RIGHT;
                    press_x_next      = pos_x;
                    press_y_next      = pos_y;
                    press_motion_next = '0;
                end
            end
            else if (released)
            begin
                if (motion_upd < click_move_limit)
                begin
                    page = 1'b1;
                    step = ctl.press_dir;
                end
                dir_next = DIR_NONE;
            end
        end
    end

    always_comb
    begin
        ctl_next.press_dir = dir_next;
        ctl_next.pen_valid = 1'b0;
        pen_load           = 1'b0;
        result_kind        = KIND_NONE;
        page_step          = STEP_ZERO;
        from_x             = '0;
        from_y             = '0;
        to_x               = '0;
        to_y               = '0;
        if (page)
        begin
            result_kind = KIND_PAGE;
            page_step   = step;
        end
        else if (button_flags == FLAGS_LEFT_ONLY)
        begin
            ctl_next.pen_valid = 1'b1;
            pen_load           = 1'b1;
            if (!ctl.pen_valid)
            begin
                result_kind = KIND_POINT;
                from_x      = pos_x;
                from_y      = pos_y;
            end
            else
            begin
                result_kind = KIND_SEGMENT;
                from_x      = pen_x;
                from_y      = pen_y;
                to_x        = pos_x;
                to_y        = pos_y;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mcdd_checker.sv =====
// mcdd_checker: port-level checks on the result stream of the decoder, bound to the top level
// depends on mcdd_pkg and mouse_click_drag_decoder
`timescale 1ns / 1ps
`default_nettype none

module mcdd_checker import mcdd_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [1:0]                          m_tuser,
    input wire logic [((2+4*COORD_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int C = COORD_BITS;

    logic [1:0]     step;
    logic [2*C-1:0] from_xy;
    logic [2*C-1:0] to_xy;

    assign step    = m_tdata[1:0];
    assign from_xy = m_tdata[2 +: 2*C];
    assign to_xy   = m_tdata[2+2*C +: 2*C];

    // a page command carries a real direction and no coordinates
    a_page_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_PAGE) |->
            ((step == STEP_NEXT) || (step == STEP_PREV)) && (from_xy == '0) && (to_xy == '0))
        else $error("page command with bad step or nonzero coordinates");

    // only a page command has a step
    a_step_only_page: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_PAGE) |-> (step == STEP_ZERO))
        else $error("page step on a non-page result");

    // empty result has no coordinates, a single point has no end point
    a_unused_coords: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == KIND_NONE) || (m_tuser == KIND_POINT)) |->
            (to_xy == '0) && ((m_tuser == KIND_POINT) || (from_xy == '0)))
        else $error("coordinates set on a result kind that has none");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind mouse_click_drag_decoder mcdd_checker #(
    .COORD_BITS (COORD_BITS)
) u_mcdd_checker (.*);

`default_nettype wire
